/* rtl/srd_pkg.sv */
// Shared widths, constants and pipeline payload types for the scaled rounded divider.
// Depends on nothing; imported by every module under rtl/.
package srd_pkg;

  localparam int DATA_W     = 64;
  localparam int SHIFT_W    = 6;
  localparam int HIGH_W     = 32;
  localparam int DIVIDEND_W = DATA_W + HIGH_W;
  localparam int NUM_STEPS  = DIVIDEND_W;

  // Largest legal shift of the numerator.
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(HIGH_W);

  // Special-case flags carried alongside each item.
  typedef struct packed {
    logic shift_error;
    logic div_zero;
  } srd_flags_t;

  // Payload of one divider stage. The dq word holds the dividend bits not yet
  // consumed in its upper part and the quotient bits produced so far in its
  // lower part; it shifts left by one bit per step.
  typedef struct packed {
    logic [DIVIDEND_W-1:0] dq;
    logic [DATA_W-1:0]     rem;
    logic [DATA_W-1:0]     divisor;
    srd_flags_t            flags;
  } srd_work_t;

endpackage

/* rtl/scaled_rounded_divide_96by64.sv */
// Top level of the scaled rounded 96-by-64 divider: input stage, divider steps, rounding.
// Depends on srd_pkg, srd_prep, srd_div_step and srd_round.
//
//   Channel | Handshake            | Fields
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_ready  | numerator[63:0], divisor[63:0], shift_amount[5:0]
//   output  | out_valid / out_ready| quotient[63:0], overflow, shift_error
//
// The pipeline has one input stage, one stage per quotient bit (96 steps of a 65-bit
// compare and subtract), one rounding stage and the output register. One item enters
// per cycle unless an output stall fills the pipe. Reset (rst, synchronous) clears only
// the valid bits. A stall at the output holds only the full stages behind it;
// empty stages keep filling, so no transfer is lost or repeated.
module scaled_rounded_divide_96by64 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srd_pkg::DATA_W-1:0]    numerator,
  input  logic [srd_pkg::DATA_W-1:0]    divisor,
  input  logic [srd_pkg::SHIFT_W-1:0]   shift_amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srd_pkg::DATA_W-1:0]    quotient,
  output logic                          overflow,
  output logic                          shift_error
);
  import srd_pkg::*;

  // Index 0 is the input stage; index k is the output of divider step k.
  logic      stage_valid [NUM_STEPS+1];
  srd_work_t stage_work  [NUM_STEPS+1];
  logic      stage_hold  [NUM_STEPS+1];
  logic      round_hold;

  assign in_ready = !stage_hold[0];

  srd_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .numerator    (numerator),
    .divisor      (divisor),
    .shift_amount (shift_amount),
    .hold_down    (stage_hold[1]),
    .out_valid    (stage_valid[0]),
    .out_work     (stage_work[0]),
    .hold         (stage_hold[0])
  );

  // One divider step per quotient bit.
  for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
    logic down_hold;
    if (k == NUM_STEPS) begin : g_last
      assign down_hold = round_hold;
    end else begin : g_mid
      assign down_hold = stage_hold[k+1];
    end

    srd_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k-1]),
      .in_work   (stage_work[k-1]),
      .hold_down (down_hold),
      .out_valid (stage_valid[k]),
      .out_work  (stage_work[k]),
      .hold      (stage_hold[k])
    );
  end

  srd_round u_round (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (stage_valid[NUM_STEPS]),
    .in_work     (stage_work[NUM_STEPS]),
    .hold        (round_hold),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .quotient    (quotient),
    .overflow    (overflow),
    .shift_error (shift_error)
  );

endmodule

/* rtl/srd_prep.sv */
// Input stage: forms the 96-bit scaled dividend and the special-case flags.
// Depends on srd_pkg.
module srd_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [srd_pkg::DATA_W-1:0]    numerator,
  input  logic [srd_pkg::DATA_W-1:0]    divisor,
  input  logic [srd_pkg::SHIFT_W-1:0]   shift_amount,
  input  logic                          hold_down,
  output logic                          out_valid,
  output srd_pkg::srd_work_t            out_work,
  output logic                          hold
);
  import srd_pkg::*;

  srd_work_t work_next;

  // The stage keeps its item only while it is full and the next stage is blocked.
  assign hold = out_valid && hold_down;

  // Scale the numerator and classify the item.
  always_comb begin
    work_next.dq                = DIVIDEND_W'(numerator) << shift_amount;
    work_next.rem               = '0;
    work_next.divisor           = divisor;
    work_next.flags.shift_error = (shift_amount > MAX_SHIFT);
    work_next.flags.div_zero    = (divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      out_work <= work_next;
    end
  end

endmodule

/* rtl/srd_div_step.sv */
// One registered step of the restoring divider: yields one quotient bit.
// Depends on srd_pkg.
module srd_div_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  srd_pkg::srd_work_t in_work,
  input  logic               hold_down,
  output logic               out_valid,
  output srd_pkg::srd_work_t out_work,
  output logic               hold
);
  import srd_pkg::*;

  logic [DATA_W:0]   partial;
  logic [DATA_W:0]   diff;
  logic              take;
  srd_work_t         work_next;

  assign hold = out_valid && hold_down;

  // Bring in the next dividend bit, then subtract the divisor when it fits.
  always_comb begin
    partial   = {in_work.rem, in_work.dq[DIVIDEND_W-1]};
    diff      = partial - {1'b0, in_work.divisor};
    take      = (partial >= {1'b0, in_work.divisor});
    work_next = in_work;
    work_next.rem = take ? diff[DATA_W-1:0] : partial[DATA_W-1:0];
    work_next.dq  = {in_work.dq[DIVIDEND_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      out_work <= work_next;
    end
  end

endmodule

/* rtl/srd_round.sv */
// Two output stages: the round-half-up decision, then the increment,
// saturation and special-case selection into the output register. Depends on srd_pkg.
module srd_round (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  srd_pkg::srd_work_t          in_work,
  output logic                        hold,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [srd_pkg::DATA_W-1:0]  quotient,
  output logic                        overflow,
  output logic                        shift_error
);
  import srd_pkg::*;

  logic                  mid_valid;
  logic [DIVIDEND_W-1:0] mid_q;
  logic                  mid_up;
  srd_flags_t            mid_flags;
  logic                  mid_hold;
  logic                  out_hold;
  logic                  round_up;
  logic [DIVIDEND_W:0]   sum;
  logic                  too_big;
  logic [DATA_W-1:0]     quotient_next;
  logic                  overflow_next;

  assign out_hold = out_valid && !out_ready;
  assign mid_hold = mid_valid && out_hold;
  assign hold     = mid_hold;

  // Round up when twice the remainder is at least the divisor.
  assign round_up = ({in_work.rem, 1'b0} >= {1'b0, in_work.divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (!mid_hold) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!mid_hold) begin
      mid_q     <= in_work.dq;
      mid_up    <= round_up;
      mid_flags <= in_work.flags;
    end
  end

  // Increment, saturate, and force zero for the special cases.
  always_comb begin
    sum     = {1'b0, mid_q} + (DIVIDEND_W + 1)'(mid_up);
    too_big = |sum[DIVIDEND_W:DATA_W];
    if (mid_flags.shift_error || mid_flags.div_zero) begin
      quotient_next = '0;
      overflow_next = 1'b0;
    end else if (too_big) begin
      quotient_next = '1;
      overflow_next = 1'b1;
    end else begin
      quotient_next = sum[DATA_W-1:0];
      overflow_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_hold) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) begin
      quotient    <= quotient_next;
      overflow    <= overflow_next;
      shift_error <= mid_flags.shift_error;
    end
  end

endmodule

/* tb/scaled_rounded_divide_96by64_tb.sv */
`timescale 1ns / 100ps
// Testbench for the scaled rounded divider: directed corners, then random traffic
// under mixed idling. Depends on srd_pkg and scaled_rounded_divide_96by64; the
// expected quotients come from its own predictor.
module scaled_rounded_divide_96by64_tb;
  import srd_pkg::*;

  localparam int PIPE_LATENCY = 99;
  localparam int STALL_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;

  // One expected or observed result transfer.
  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic              overflow;
    logic              shift_error;
  } quot_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [DATA_W-1:0]   numerator;
  logic [DATA_W-1:0]   divisor;
  logic [SHIFT_W-1:0]  shift_amount;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   quotient;
  logic                overflow;
  logic                shift_error;

  quot_result_t pending_quotients[$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int divisions_sent = 0;
  int results_seen   = 0;
  int shift_errs     = 0;
  int saturations    = 0;
  int quiet_cycles   = 0;

  scaled_rounded_divide_96by64 DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .numerator    (numerator),
    .divisor      (divisor),
    .shift_amount (shift_amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .quotient     (quotient),
    .overflow     (overflow),
    .shift_error  (shift_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Scale, divide and round half up in wide arithmetic; saturate above 64 bits.
  function automatic quot_result_t predict_quotient(input logic [DATA_W-1:0] num,
                                                    input logic [DATA_W-1:0] div,
                                                    input logic [SHIFT_W-1:0] sh);
    logic [127:0] dividend;
    logic [127:0] wide_div;
    logic [127:0] full_q;
    logic [127:0] part_r;
    quot_result_t res;
    res = '0;
    wide_div = {64'd0, div};
    if (sh > MAX_SHIFT) begin
      res.shift_error = 1'b1;
    end else if (div != '0) begin
      dividend = {64'd0, num} << sh;
      full_q   = dividend / wide_div;
      part_r   = dividend % wide_div;
      if ((part_r << 1) >= wide_div) begin
        full_q = full_q + 128'd1;
      end
      if (full_q[127:64] != '0) begin
        res.quotient = '1;
        res.overflow = 1'b1;
      end else begin
        res.quotient = full_q[63:0];
      end
    end
    return res;
  endfunction

  // Random value whose highest set bit sits at a chosen width.
  function automatic logic [DATA_W-1:0] rand_of_width(input int width);
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    if (width < DATA_W) begin
      v = v & ((64'd1 << width) - 64'd1);
    end
    v[width-1] = 1'b1;
    return v;
  endfunction

  // Offer one division, wait for its transfer and record the expected result.
  task automatic send_division(input logic [DATA_W-1:0] num, input logic [DATA_W-1:0] div,
                               input logic [SHIFT_W-1:0] sh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    numerator    <= num;
    divisor      <= div;
    shift_amount <= sh;
    do @(posedge clk); while (!in_ready);
    pending_quotients.push_back(predict_quotient(num, div, sh));
    divisions_sent++;
  endtask

  // Shifts above the limit, at the limit, and together with a zero divisor.
  task automatic test_shift_errors();
    send_division('1, 64'd1, 6'd33);
    send_division('1, 64'd0, 6'd40);
    send_division(64'd0, 64'd5, 6'd63);
    send_division(64'd1, 64'd1, MAX_SHIFT);
  endtask

  task automatic test_zero_divisor();
    send_division('1, 64'd0, 6'd0);
    send_division(64'd0, 64'd0, MAX_SHIFT);
    send_division(64'd123, 64'd0, 6'd17);
  endtask

  // Exact halves round up; a remainder with its top bit set must still round.
  task automatic test_rounding();
    send_division(64'd1, 64'd2, 6'd0);
    send_division(64'd3, 64'd2, 6'd0);
    send_division(64'd1, 64'd3, 6'd0);
    send_division(64'd2, 64'd3, 6'd0);
    send_division(64'd5, 64'd4, 6'd0);
    send_division(64'd7, 64'd4, 6'd0);
    send_division('1, 64'h8000_0000_0000_0001, 6'd0);
    send_division(64'hC000_0000_0000_0000, '1, 6'd1);
  endtask

  // Largest quotients that fit, and the first ones that do not.
  task automatic test_saturation();
    send_division('1, 64'd1, 6'd0);
    send_division('1, 64'd2, 6'd1);
    send_division(64'h8000_0000_0000_0000, 64'd1, 6'd1);
    send_division('1, 64'd1, MAX_SHIFT);
    send_division('1, '1, MAX_SHIFT);
    send_division('1, '1, 6'd0);
    send_division(64'd0, '1, MAX_SHIFT);
    send_division('1, 64'hFFFF_FFFF_FFFF_FFFE, 6'd0);
  endtask

  // Random operands with random bit widths, so results land both in range and saturated.
  task automatic test_random_divisions(input int count);
    logic [DATA_W-1:0]  num;
    logic [DATA_W-1:0]  div;
    logic [SHIFT_W-1:0] sh;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) num = '1;
      else if (pick < 8) num = '0;
      else num = rand_of_width($urandom_range(DATA_W, 1));
      pick = $urandom_range(99);
      if (pick < 3) div = '0;
      else if (pick < 10) div = DATA_W'($urandom_range(16, 1));
      else if (pick < 20) div = {$urandom, $urandom};
      else div = rand_of_width($urandom_range(DATA_W, 1));
      if ($urandom_range(99) < 8) sh = SHIFT_W'($urandom_range(63, 33));
      else sh = SHIFT_W'($urandom_range(32, 0));
      send_division(num, div, sh);
    end
  endtask

  // Receiver stalls at the rate set for the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    quot_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_quotients.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Unexpected result: quotient=%h overflow=%b shift_error=%b",
                   quotient, overflow, shift_error);
        end
      end else begin
        want = pending_quotients.pop_front();
        if (want.shift_error) shift_errs++;
        if (want.overflow) saturations++;
        if (quotient !== want.quotient || overflow !== want.overflow ||
            shift_error !== want.shift_error) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Mismatch: expected quotient=%h overflow=%b shift_error=%b",
                     want.quotient, want.overflow, want.shift_error);
            $display("          actual   quotient=%h overflow=%b shift_error=%b",
                     quotient, overflow, shift_error);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    numerator    <= '0;
    divisor      <= '0;
    shift_amount <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly while the receiver stalls heavily.
    send_idle_pct  = 25;
    recv_stall_pct = 69;
    test_shift_errors();
    test_zero_divisor();
    test_rounding();
    test_saturation();
    test_random_divisions(630);

    // The other way round.
    send_idle_pct  = 69;
    recv_stall_pct = 25;
    test_random_divisions(630);

    // Full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_divisions(640);

    in_valid <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (pending_quotients.size() != 0) error_count++;

    $display("Sent %0d divisions across three idle mixes; %0d shift errors, %0d saturated.",
             divisions_sent, shift_errs, saturations);
    $display("Checked %0d results, %0d failures.", results_seen, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* scaled_rounded_divide_96by64.f */
rtl/srd_pkg.sv
rtl/srd_prep.sv
rtl/srd_div_step.sv
rtl/srd_round.sv
rtl/scaled_rounded_divide_96by64.sv
tb/scaled_rounded_divide_96by64_tb.sv
